### hdl/spring_damped_brush_stroke_macros.svh
// Assertion macros for the spring-damper brush block.
// Used by the top level; compiled out when SYNTH is defined.
`ifndef SPRING_DAMPED_BRUSH_STROKE_MACROS_SVH
`define SPRING_DAMPED_BRUSH_STROKE_MACROS_SVH
`ifndef SYNTH
`define SDBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdbs assertion failed");
`define SDBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdbs assertion failed");
`else
`define SDBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/sdbs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and fixed-point helpers for the brush block.
// No dependencies.
package sdbs_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int REG_W     = 16;
    localparam int WIN_W     = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [REG_W-1:0] RST_SPRING_K  = 16'd3932;
    localparam logic [REG_W-1:0] RST_DAMPING   = 16'd45875;
    localparam logic [REG_W-1:0] RST_INV_MASS  = 16'd256;
    localparam logic [REG_W-1:0] RST_MIN_WIDTH = 16'd256;
    localparam logic [REG_W-1:0] RST_MAX_WIDTH = 16'd3840;
    localparam logic [WIN_W-1:0] RST_WIN_W     = 12'd640;
    localparam logic [WIN_W-1:0] RST_WIN_H     = 12'd480;

    // 60 px in Q.8 and its square
    localparam logic [13:0] SPEED_CAP  = 14'd15360;
    localparam logic [31:0] SPEED_DEN  = 32'd235929600;
    localparam logic [31:0] SPEED_HALF = SPEED_DEN / 2;

    // square is 225 * 2^20: shift by 20, then multiply by ceil(2^33 / 225)
    localparam int          SPEED_PSH   = 20;
    localparam logic [31:0] SPEED_RECIP = 32'd38177488;
    localparam int          SPEED_RSH   = 33;

    localparam int DIV_STEPS  = 48;
    localparam int SQRT_STEPS = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRING_K  = 3'd0,
        REG_DAMPING   = 3'd1,
        REG_INV_MASS  = 3'd2,
        REG_MIN_WIDTH = 3'd3,
        REG_MAX_WIDTH = 3'd4,
        REG_WIN_W     = 3'd5,
        REG_WIN_H     = 3'd6
    } t_reg_idx;

    // round half away from zero on a magnitude
    function automatic logic [63:0] rnd_shr(input logic [63:0] p, input int unsigned sh);
        logic [63:0] half;
        half = 64'(1) << (sh - 1);
        return (p + half) >> sh;
    endfunction

    function automatic logic signed [31:0] sat_state(input logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'h7FFF;
        end else if (v < -20'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

endpackage

### hdl/sdbs_in_if.sv
`timescale 1ns / 1ps
// Input channel of the brush block: one cursor sample per item.
// Depends on sdbs_pkg.
interface sdbs_in_if import sdbs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] cursor_x;
    logic [IN_W-1:0] cursor_y;

    modport source (output valid, output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

### hdl/sdbs_out_if.sv
`timescale 1ns / 1ps
// Output channel of the brush block: brush point and half-width vector.
// Depends on sdbs_pkg.
interface sdbs_out_if import sdbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic signed [OUT_W-1:0] half_width_x;
    logic signed [OUT_W-1:0] half_width_y;

    modport source (output valid, output point_x, output point_y,
                    output half_width_x, output half_width_y, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input half_width_x, input half_width_y, output ready);
endinterface

### hdl/spring_damped_brush_stroke.sv
// Spring-damper brush: one 32x32 multiplier, a bit-serial divider and a
// bit-pair square root, sequenced by one state machine; one item at a time.
// The 48-step divider runs two passes and the 31-step square root two; at zero velocity
// only the first square root runs, and normalising shifts and both divider passes are skipped.
// A new item is taken the cycle after the result is loaded into the output register.
// Synchronous active-low reset restores register defaults and forgets the brush.
`timescale 1ns / 1ps
`include "spring_damped_brush_stroke_macros.svh"
module spring_damped_brush_stroke import sdbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    sdbs_in_if.sink              i_in,
    sdbs_out_if.source           o_out
);

    typedef enum logic [4:0] {
        S_IDLE, S_FX, S_FY, S_AX, S_AY, S_DX, S_DY, S_POS, S_PX, S_PY,
        S_SX, S_SY, S_SQX, S_SQY, S_RT1, S_SS, S_NUM, S_QW, S_WID, S_NORM,
        S_NXX, S_NYY, S_RT2, S_EX, S_DV2, S_EY, S_DV3, S_HY, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_LOAD, PH_WAIT, PH_USE} t_phase;

    logic [REG_W-1:0] r_spring_k, r_damping, r_inv_mass, r_min_width, r_max_width;
    logic [WIN_W-1:0] r_win_w, r_win_h;

    t_state r_state;
    t_phase r_ph;
    logic   r_started;

    logic signed [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic [IN_W-1:0]    r_cx, r_cy;
    logic [31:0]        r_ma, r_mb;
    logic [63:0]        r_prod;
    logic               r_neg;
    logic [31:0]        r_fx_mag, r_fy_mag;
    logic               r_fx_neg, r_fy_neg;
    logic [13:0]        r_sx;
    logic [27:0]        r_s2;
    logic signed [18:0] r_w;
    logic [31:0]        r_nx, r_ny;
    logic [61:0]        r_rx, r_rr, r_bit;
    logic [4:0]         r_cnt;
    logic [47:0]        r_dq;
    logic [31:0]        r_rem, r_dvs;
    logic [5:0]         r_dcnt;
    logic [15:0]        r_px, r_py, r_hx, r_hy;
    logic               r_ovalid;
    logic [15:0]        r_o_px, r_o_py, r_o_hx, r_o_hy;

    logic signed [32:0] c_dx, c_dy, c_d;
    logic [31:0]        c_dmag;
    logic [63:0]        c_r16, c_r8, c_r26, c_r22;
    logic signed [31:0] c_vsel, c_vacc, c_vdmp, c_posx, c_posy;
    logic signed [41:0] c_acc;
    logic [15:0]        c_pix;
    logic [13:0]        c_spd, c_smin;
    logic [61:0]        c_rt;
    logic               c_rge;
    logic [32:0]        c_dt;
    logic               c_dge;
    logic [31:0]        c_dsub;
    logic [31:0]        c_big;
    logic [14:0]        c_q15;
    logic [15:0]        c_hmag, c_hx, c_hy;
    logic signed [16:0] c_wdiff;
    logic [15:0]        c_wdmag;
    logic signed [18:0] c_w;
    logic [17:0]        c_wmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_k  <= RST_SPRING_K;
            r_damping   <= RST_DAMPING;
            r_inv_mass  <= RST_INV_MASS;
            r_min_width <= RST_MIN_WIDTH;
            r_max_width <= RST_MAX_WIDTH;
            r_win_w     <= RST_WIN_W;
            r_win_h     <= RST_WIN_H;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SPRING_K:  r_spring_k  <= i_cfg_data;
                REG_DAMPING:   r_damping   <= i_cfg_data;
                REG_INV_MASS:  r_inv_mass  <= i_cfg_data;
                REG_MIN_WIDTH: r_min_width <= i_cfg_data;
                REG_MAX_WIDTH: r_max_width <= i_cfg_data;
                REG_WIN_W:     r_win_w     <= i_cfg_data[WIN_W-1:0];
                REG_WIN_H:     r_win_h     <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(r_ma) * 64'(r_mb);
    end

    always_comb begin
        c_dx    = $signed({r_pos_x[31], r_pos_x}) - $signed({3'b000, r_cx, 14'd0});
        c_dy    = $signed({r_pos_y[31], r_pos_y}) - $signed({3'b000, r_cy, 14'd0});
        c_d     = (r_state == S_FX) ? c_dx : c_dy;
        c_dmag  = c_d[32] ? 32'(-c_d) : c_d[31:0];
        c_r16   = rnd_shr(r_prod, 16);
        c_r8    = rnd_shr(r_prod, 8);
        c_r26   = rnd_shr(r_prod, 26);
        c_r22   = rnd_shr(r_prod, 22);
        c_vsel  = (r_state == S_AX || r_state == S_DX) ? r_vel_x : r_vel_y;
        c_acc   = r_neg ? -$signed({1'b0, c_r8[40:0]}) : $signed({1'b0, c_r8[40:0]});
        c_vacc  = sat_state($signed({{10{c_vsel[31]}}, c_vsel}) + c_acc);
        c_vdmp  = sat_state(r_neg ? -$signed({10'b0, c_r16[31:0]})
                                  : $signed({10'b0, c_r16[31:0]}));
        c_posx  = sat_state($signed({{10{r_pos_x[31]}}, r_pos_x})
                          + $signed({{10{r_vel_x[31]}}, r_vel_x}));
        c_posy  = sat_state($signed({{10{r_pos_y[31]}}, r_pos_y})
                          + $signed({{10{r_vel_y[31]}}, r_vel_y}));
        c_pix   = sat16(r_neg ? -$signed({1'b0, c_r26[18:0]}) : $signed({1'b0, c_r26[18:0]}));
        c_spd   = (c_r22 > 64'(SPEED_CAP)) ? SPEED_CAP : c_r22[13:0];
        c_smin  = (r_rr > 62'(SPEED_CAP)) ? SPEED_CAP : r_rr[13:0];
        c_rt    = r_rr + r_bit;
        c_rge   = (r_rx >= c_rt);
        c_dt    = {r_rem, r_dq[47]};
        c_dge   = (c_dt >= {1'b0, r_dvs});
        c_dsub  = 32'(c_dt - {1'b0, r_dvs});
        c_big   = (r_nx > r_ny) ? r_nx : r_ny;
        c_q15   = (r_dq[47:15] != '0) ? 15'h7FFF : r_dq[14:0];
        c_hmag  = {1'b0, c_q15};
        c_hx    = (r_vel_y == 0) ? 16'd0
                : ((!r_vel_y[31] ^ r_w[18]) ? 16'(-c_hmag) : c_hmag);
        c_hy    = (r_vel_x == 0) ? 16'd0
                : ((r_vel_x[31] ^ r_w[18]) ? 16'(-c_hmag) : c_hmag);
        c_wdiff = $signed({1'b0, r_max_width}) - $signed({1'b0, r_min_width});
        c_wdmag = c_wdiff[16] ? 16'(-c_wdiff) : c_wdiff[15:0];
        c_w     = $signed({3'b000, r_min_width})
                + (r_neg ? -$signed({2'b00, r_dq[16:0]}) : $signed({2'b00, r_dq[16:0]}));
        c_wmag  = r_w[18] ? 18'(-r_w) : r_w[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ph      <= PH_LOAD;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
        end else begin
            if (r_ovalid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            if (r_ph == PH_WAIT) begin
                r_ph <= PH_USE;
            end
            if (r_state == S_RT1 || r_state == S_RT2) begin
                if (c_rge) begin
                    r_rx <= r_rx - c_rt;
                    r_rr <= (r_rr >> 1) + r_bit;
                end else begin
                    r_rr <= r_rr >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            if (r_state == S_DV2 || r_state == S_DV3) begin
                r_rem  <= c_dge ? c_dsub : c_dt[31:0];
                r_dq   <= {r_dq[46:0], c_dge};
                r_dcnt <= r_dcnt + 6'd1;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cx <= i_in.cursor_x;
                        r_cy <= i_in.cursor_y;
                        if (!r_started) begin
                            r_pos_x   <= {2'b00, i_in.cursor_x, 14'd0};
                            r_pos_y   <= {2'b00, i_in.cursor_y, 14'd0};
                            r_vel_x   <= '0;
                            r_vel_y   <= '0;
                            r_started <= 1'b1;
                        end
                        r_state <= S_FX;
                        r_ph    <= PH_LOAD;
                    end
                end
                S_FX, S_FY: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma  <= c_dmag;
                        r_mb  <= {16'd0, r_spring_k};
                        r_neg <= !c_d[32];
                        r_ph  <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        if (r_state == S_FX) begin
                            r_fx_mag <= c_r16[31:0];
                            r_fx_neg <= r_neg;
                            r_state  <= S_FY;
                        end else begin
                            r_fy_mag <= c_r16[31:0];
                            r_fy_neg <= r_neg;
                            r_state  <= S_AX;
                        end
                        r_ph <= PH_LOAD;
                    end
                end
                S_AX, S_AY: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma  <= (r_state == S_AX) ? r_fx_mag : r_fy_mag;
                        r_neg <= (r_state == S_AX) ? r_fx_neg : r_fy_neg;
                        r_mb  <= {16'd0, r_inv_mass};
                        r_ph  <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        if (r_state == S_AX) begin
                            r_vel_x <= c_vacc;
                            r_state <= S_AY;
                        end else begin
                            r_vel_y <= c_vacc;
                            r_state <= S_DX;
                        end
                        r_ph <= PH_LOAD;
                    end
                end
                S_DX, S_DY: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma  <= mag32(c_vsel);
                        r_neg <= c_vsel[31];
                        r_mb  <= {16'd0, r_damping};
                        r_ph  <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        if (r_state == S_DX) begin
                            r_vel_x <= c_vdmp;
                            r_state <= S_DY;
                        end else begin
                            r_vel_y <= c_vdmp;
                            r_state <= S_POS;
                        end
                        r_ph <= PH_LOAD;
                    end
                end
                S_POS: begin
                    r_pos_x <= c_posx;
                    r_pos_y <= c_posy;
                    r_state <= S_PX;
                end
                S_PX, S_PY: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma  <= mag32((r_state == S_PX) ? r_pos_x : r_pos_y);
                        r_neg <= (r_state == S_PX) ? r_pos_x[31] : r_pos_y[31];
                        r_mb  <= {20'd0, (r_state == S_PX) ? r_win_w : r_win_h};
                        r_ph  <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        if (r_state == S_PX) begin
                            r_px    <= c_pix;
                            r_state <= S_PY;
                        end else begin
                            r_py    <= c_pix;
                            r_state <= S_SX;
                        end
                        r_ph <= PH_LOAD;
                    end
                end
                S_SX, S_SY: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma <= mag32((r_state == S_SX) ? r_vel_x : r_vel_y);
                        r_mb <= {20'd0, (r_state == S_SX) ? r_win_w : r_win_h};
                        r_ph <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        if (r_state == S_SX) begin
                            r_sx    <= c_spd;
                            r_state <= S_SY;
                        end else begin
                            r_ma    <= {18'd0, r_sx};
                            r_mb    <= {18'd0, r_sx};
                            r_sx    <= c_spd;
                            r_state <= S_SQX;
                        end
                        r_ph <= (r_state == S_SX) ? PH_LOAD : PH_WAIT;
                    end
                end
                S_SQX, S_NXX: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma <= r_nx;
                        r_mb <= r_nx;
                        r_ph <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        r_rx    <= r_prod[61:0];
                        r_state <= (r_state == S_SQX) ? S_SQY : S_NYY;
                        r_ph    <= PH_LOAD;
                    end
                end
                S_SQY, S_NYY: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma <= (r_state == S_SQY) ? {18'd0, r_sx} : r_ny;
                        r_mb <= (r_state == S_SQY) ? {18'd0, r_sx} : r_ny;
                        r_ph <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        r_rx    <= r_rx + r_prod[61:0];
                        r_rr    <= '0;
                        r_bit   <= 62'(1) << 60;
                        r_cnt   <= '0;
                        r_state <= (r_state == S_SQY) ? S_RT1 : S_RT2;
                        r_ph    <= PH_LOAD;
                    end
                end
                S_RT1: begin
                    if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                        r_state <= S_SS;
                    end
                end
                S_SS: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma <= {18'd0, c_smin};
                        r_mb <= {18'd0, c_smin};
                        r_ph <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        r_s2    <= r_prod[27:0];
                        r_state <= S_NUM;
                        r_ph    <= PH_LOAD;
                    end
                end
                S_NUM: begin
                    if (r_ph == PH_LOAD) begin
                        r_ma  <= {4'd0, r_s2};
                        r_mb  <= {16'd0, c_wdmag};
                        r_neg <= c_wdiff[16];
                        r_ph  <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        r_ma    <= 32'((r_prod[47:0] + 48'(SPEED_HALF)) >> SPEED_PSH);
                        r_mb    <= SPEED_RECIP;
                        r_state <= S_QW;
                        r_ph    <= PH_WAIT;
                    end
                end
                S_QW: begin
                    if (r_ph == PH_USE) begin
                        r_dq    <= 48'(r_prod >> SPEED_RSH);
                        r_state <= S_WID;
                        r_ph    <= PH_LOAD;
                    end
                end
                S_WID: begin
                    r_w  <= c_w;
                    r_nx <= mag32(r_vel_x);
                    r_ny <= mag32(r_vel_y);
                    if (r_vel_x == 0 && r_vel_y == 0) begin
                        r_hx    <= '0;
                        r_hy    <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (c_big[31:30] != 2'b00) begin
                        r_nx <= r_nx >> 1;
                        r_ny <= r_ny >> 1;
                    end else if (!c_big[29]) begin
                        r_nx <= r_nx << 1;
                        r_ny <= r_ny << 1;
                    end else begin
                        r_state <= S_NXX;
                    end
                end
                S_RT2: begin
                    if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                        r_state <= S_EX;
                    end
                end
                S_EX, S_EY: begin
                    if (r_ph == PH_LOAD) begin
                        if (r_state == S_EX) begin
                            r_dvs <= r_rr[31:0];
                            r_ma  <= r_ny;
                        end else begin
                            r_hx <= c_hx;
                            r_ma <= r_nx;
                        end
                        r_mb <= {14'd0, c_wmag};
                        r_ph <= PH_WAIT;
                    end else if (r_ph == PH_USE) begin
                        r_dq    <= r_prod[47:0] + {17'd0, r_dvs[31:1]};
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= (r_state == S_EX) ? S_DV2 : S_DV3;
                        r_ph    <= PH_LOAD;
                    end
                end
                S_DV2: begin
                    if (r_dcnt == 6'(DIV_STEPS - 1)) begin
                        r_state <= S_EY;
                    end
                end
                S_DV3: begin
                    if (r_dcnt == 6'(DIV_STEPS - 1)) begin
                        r_state <= S_HY;
                    end
                end
                S_HY: begin
                    r_hy    <= c_hy;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_o_px   <= r_px;
                        r_o_py   <= r_py;
                        r_o_hx   <= r_hx;
                        r_o_hy   <= r_hy;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ph    <= PH_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.point_x      = $signed(r_o_px);
    assign o_out.point_y      = $signed(r_o_py);
    assign o_out.half_width_x = $signed(r_o_hx);
    assign o_out.half_width_y = $signed(r_o_hy);

    `SDBS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `SDBS_ASSERT_NXT(a_started_sticky, i_clk, i_rst_n, r_started, r_started)
    `SDBS_ASSERT_IMP(a_load_from_out, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state) == S_OUT)

endmodule

### test/spring_damped_brush_stroke_test.sv
`timescale 1ns / 1ps
// Self-checking bench for spring_damped_brush_stroke: random bursts of cursor items,
// an in-bench brush model for expected points and half-width vectors, random stalls.
// Depends on sdbs_pkg, sdbs_in_if, sdbs_out_if and the block itself.
module spring_damped_brush_stroke_test;
    import sdbs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int NUM_REGS   = 7;
    localparam int IDLE_LIMIT = 8000;
    localparam int HOLD_LEN   = 1500;
    localparam longint ST_HI  = 64'sd2147483647;
    localparam longint unsigned CAP = 64'd15360;

    typedef struct packed {
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
    } cursor_t;

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] hx;
        logic [15:0] hy;
    } stroke_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [REG_W-1:0] i_cfg_data = '0;

    sdbs_in_if  in_if();
    sdbs_out_if out_if();

    spring_damped_brush_stroke u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    cursor_t pending_cursors[$];
    stroke_t expected_strokes[$];
    logic [15:0] cfg_shadow[NUM_REGS];
    longint pos_x, pos_y, vel_x, vel_y;
    bit brush_started;
    int errors;
    int idle_cycles;
    bit in_taken;
    bit hold_start;
    cursor_t last_cursor;

    initial begin
        in_if.valid = 1'b0;
        in_if.cursor_x = '0;
        in_if.cursor_y = '0;
        out_if.ready = 1'b0;
    end

    function automatic longint unsigned mag64(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic longint mul_rnd(longint a, longint unsigned b, int sh);
        longint unsigned m, lo, r;
        m  = mag64(a);
        lo = (64'd1 << sh) - 1;
        r  = (m >> sh) * b + (((m & lo) * b + (64'd1 << (sh - 1))) >> sh);
        return a < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_st(longint v);
        if (v > ST_HI) return ST_HI;
        if (v < -ST_HI - 1) return -ST_HI - 1;
        return v;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint unsigned speed_clamp(longint v);
        longint unsigned m;
        m = mag64(v);
        return m > CAP ? CAP : m;
    endfunction

    task automatic brush_step(input cursor_t c);
        longint cx, cy, fx, fy, px, py, w, hx, hy, num, q, ex, ey;
        longint unsigned k, dmp, im, ww, wh, sx, sy, s, ax, ay, big, n, wm, den;
        stroke_t e;
        cx  = longint'(c.x) << 14;
        cy  = longint'(c.y) << 14;
        k   = cfg_shadow[REG_SPRING_K];
        dmp = cfg_shadow[REG_DAMPING];
        im  = cfg_shadow[REG_INV_MASS];
        ww  = cfg_shadow[REG_WIN_W];
        wh  = cfg_shadow[REG_WIN_H];
        hx  = 0;
        hy  = 0;
        if (!brush_started) begin
            pos_x = cx;
            pos_y = cy;
            vel_x = 0;
            vel_y = 0;
            brush_started = 1;
        end
        fx = -mul_rnd(pos_x - cx, k, 16);
        fy = -mul_rnd(pos_y - cy, k, 16);
        vel_x = sat_st(vel_x + mul_rnd(fx, im, 8));
        vel_y = sat_st(vel_y + mul_rnd(fy, im, 8));
        vel_x = sat_st(mul_rnd(vel_x, dmp, 16));
        vel_y = sat_st(mul_rnd(vel_y, dmp, 16));
        pos_x = sat_st(pos_x + vel_x);
        pos_y = sat_st(pos_y + vel_y);
        px = clip16(mul_rnd(pos_x, ww, 26));
        py = clip16(mul_rnd(pos_y, wh, 26));
        sx = speed_clamp(mul_rnd(vel_x, ww, 22));
        sy = speed_clamp(mul_rnd(vel_y, wh, 22));
        s  = isqrt(sx * sx + sy * sy);
        if (s > CAP) s = CAP;
        num = (longint'(cfg_shadow[REG_MAX_WIDTH]) - longint'(cfg_shadow[REG_MIN_WIDTH]))
              * longint'(s * s);
        den = CAP * CAP;
        q   = longint'((mag64(num) + den / 2) / den);
        w   = longint'(cfg_shadow[REG_MIN_WIDTH]) + (num < 0 ? -q : q);
        ax  = mag64(vel_x);
        ay  = mag64(vel_y);
        big = ax > ay ? ax : ay;
        if (big != 0) begin
            while (big >= (64'd1 << 30)) begin
                ax >>= 1; ay >>= 1; big >>= 1;
            end
            while (big < (64'd1 << 29)) begin
                ax <<= 1; ay <<= 1; big <<= 1;
            end
            n  = isqrt(ax * ax + ay * ay);
            wm = mag64(w);
            ex = longint'((ay * wm + n / 2) / n);
            ey = longint'((ax * wm + n / 2) / n);
            if (w < 0) begin
                ex = -ex;
                ey = -ey;
            end
            hx = vel_y > 0 ? -ex : (vel_y < 0 ? ex : 0);
            hy = vel_x > 0 ? ey : (vel_x < 0 ? -ey : 0);
            hx = clip16(hx);
            hy = clip16(hy);
            if (hx == -32768) hx = -32767;
            if (hy == -32768) hy = -32767;
        end
        e.px = px[15:0];
        e.py = py[15:0];
        e.hx = hx[15:0];
        e.hy = hy[15:0];
        expected_strokes = {expected_strokes, e};
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    endtask

    // input accept and output check
    always @(posedge i_clk) begin
        stroke_t e;
        in_taken <= in_if.valid && in_if.ready;
        if (in_if.valid && in_if.ready) begin
            brush_step('{x: in_if.cursor_x, y: in_if.cursor_y});
        end
        if (out_if.valid && out_if.ready) begin
            if (expected_strokes.size() == 0) begin
                report("unexpected item", out_if.point_x, 16'd0);
            end else begin
                e = expected_strokes.pop_front();
                if (out_if.point_x !== e.px) report("point_x", out_if.point_x, e.px);
                if (out_if.point_y !== e.py) report("point_y", out_if.point_y, e.py);
                if (out_if.half_width_x !== e.hx)
                    report("half_width_x", out_if.half_width_x, e.hx);
                if (out_if.half_width_y !== e.hy)
                    report("half_width_y", out_if.half_width_y, e.hy);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        cursor_t c;
        if (i_rst_n && (!in_if.valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_cursors.size() > 0) begin
                c = pending_cursors.pop_front();
                in_if.cursor_x <= c.x;
                in_if.cursor_y <= c.y;
                in_if.valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                          : $urandom_range(0, 3);
                end else begin
                    burst_left--;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    int rx_mode = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(negedge i_clk) begin
        if (hold_start && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_LEN;
        end
        if ($urandom_range(0, 499) == 0) rx_mode = $urandom_range(0, 2);
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= ($urandom_range(0, 3) != 0);
                default: out_if.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        if (idx < NUM_REGS)
            cfg_shadow[idx] = (idx == REG_WIN_W || idx == REG_WIN_H) ? (v & 16'h0FFF) : v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] k, dmp, im, wmin, wmax, ww, wh);
        write_reg(REG_SPRING_K, k);
        write_reg(REG_DAMPING, dmp);
        write_reg(REG_INV_MASS, im);
        write_reg(REG_MIN_WIDTH, wmin);
        write_reg(REG_MAX_WIDTH, wmax);
        write_reg(REG_WIN_W, ww);
        write_reg(REG_WIN_H, wh);
    endtask

    task automatic wait_idle();
        while (pending_cursors.size() != 0 || in_if.valid || expected_strokes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_cursor(input logic [15:0] x, y);
        cursor_t c;
        c = '{x: x, y: y};
        pending_cursors = {pending_cursors, c};
        last_cursor = c;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 8192);
        endcase
    endfunction

    task automatic random_stroke(input int count);
        int dx, dy;
        repeat (count) begin
            if ($urandom_range(0, 9) < 3) begin
                push_cursor($urandom_range(0, 65535), $urandom_range(0, 65535));
            end else begin
                dx = int'(last_cursor.x) + $signed($urandom_range(0, 4096)) - 2048;
                dy = int'(last_cursor.y) + $signed($urandom_range(0, 4096)) - 2048;
                dx = dx < 0 ? 0 : (dx > 65535 ? 65535 : dx);
                dy = dy < 0 ? 0 : (dy > 65535 ? 65535 : dy);
                push_cursor(dx[15:0], dy[15:0]);
            end
        end
    endtask

    initial begin
        errors = 0;
        hold_start = 0;
        brush_started = 0;
        pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
        last_cursor = '0;
        cfg_shadow[REG_SPRING_K]  = RST_SPRING_K;
        cfg_shadow[REG_DAMPING]   = RST_DAMPING;
        cfg_shadow[REG_INV_MASS]  = RST_INV_MASS;
        cfg_shadow[REG_MIN_WIDTH] = RST_MIN_WIDTH;
        cfg_shadow[REG_MAX_WIDTH] = RST_MAX_WIDTH;
        cfg_shadow[REG_WIN_W]     = 16'(RST_WIN_W);
        cfg_shadow[REG_WIN_H]     = 16'(RST_WIN_H);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // defaults; first item puts the brush at rest on the cursor
        write_reg(REG_NONE, 16'h1234);
        push_cursor(16'd0, 16'd0);
        push_cursor(16'hFFFF, 16'hFFFF);
        push_cursor(16'hFFFF, 16'hFFFF);
        push_cursor(16'hFFFF, 16'd0);
        push_cursor(16'd0, 16'hFFFF);
        push_cursor(16'h8000, 16'h8000);
        push_cursor(16'h8000, 16'h8000);
        wait_idle();

        // every register at its top but the minimum width, which is zero: saturating state and widths
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFF, 16'hFFF);
        repeat (4) begin
            push_cursor(16'hFFFF, 16'hFFFF);
            push_cursor(16'd0, 16'd0);
        end
        push_cursor(16'hFFFF, 16'd0);
        push_cursor(16'd0, 16'hFFFF);
        wait_idle();

        // zero inverse mass, zero window width, shrinking width
        write_all(16'd1000, 16'd60000, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1);
        push_cursor(16'd0, 16'hFFFF);
        push_cursor(16'hFFFF, 16'd0);
        push_cursor(16'h4000, 16'h4000);
        wait_idle();
        write_all(16'd20000, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0);
        push_cursor(16'hFFFF, 16'hFFFF);
        push_cursor(16'd0, 16'd0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            write_all(ph[0] ? RST_SPRING_K : pick16(), ph[1] ? RST_DAMPING : pick16(),
                      ($urandom_range(0, 3) == 0) ? pick16() : 16'($urandom_range(1, 2048)),
                      pick16(), pick16(),
                      16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)));
            random_stroke(120);
            if (ph == 3) hold_start = 1;
            wait_idle();
        end

        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
